FILE: design/mkc_pkg.sv
// package for the message keyword classifier
// holds widths, keyword table, register indexes and the keyword compare function
// no dependencies
package mkc_pkg;

	localparam int HIST_LEN = 10;
	localparam int WIN_LEN  = HIST_LEN + 1;
	localparam int CHAR_W   = 8;
	localparam int SEV_W    = 3;
	localparam int CAT_W    = 10;
	localparam int CFG_W    = 10;
	localparam int CFG_IDX_W = 2;
	localparam int KW_COUNT = 30;
	localparam int KW_LEN_W = $clog2(WIN_LEN + 1);
	localparam int KW_CAT_W = $clog2(CAT_W);

	localparam logic [SEV_W-1:0] SEV_CRIT_MAX = 3'd2;
	localparam logic [SEV_W-1:0] SEV_WARN_MAX = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALLOW_MASK     = 2'd0,
		CFG_LEVEL_LIMIT    = 2'd1,
		CFG_OVERRIDE_LEVEL = 2'd2
	} cfg_idx_t;

	// text is right aligned: last character in the low byte
	typedef struct packed {
		logic [CHAR_W*WIN_LEN-1:0] text;
		logic [KW_LEN_W-1:0]       len;
		logic [KW_CAT_W-1:0]       cat;
	} kw_t;

	localparam kw_t KW_TABLE [KW_COUNT] = '{
		'{"PREARM",      KW_LEN_W'(6),  KW_CAT_W'(0)},
		'{"PA:",         KW_LEN_W'(3),  KW_CAT_W'(0)},
		'{"EKF",         KW_LEN_W'(3),  KW_CAT_W'(1)},
		'{"AHRS",        KW_LEN_W'(4),  KW_CAT_W'(1)},
		'{"DCM",         KW_LEN_W'(3),  KW_CAT_W'(1)},
		'{"GPS",         KW_LEN_W'(3),  KW_CAT_W'(2)},
		'{"GNSS",        KW_LEN_W'(4),  KW_CAT_W'(2)},
		'{"BATT",        KW_LEN_W'(4),  KW_CAT_W'(3)},
		'{"VOLT",        KW_LEN_W'(4),  KW_CAT_W'(3)},
		'{"POWER",       KW_LEN_W'(5),  KW_CAT_W'(3)},
		'{"CURRENT",     KW_LEN_W'(7),  KW_CAT_W'(3)},
		'{"CAPACITY",    KW_LEN_W'(8),  KW_CAT_W'(3)},
		'{"COMPASS",     KW_LEN_W'(7),  KW_CAT_W'(4)},
		'{"MAG ",        KW_LEN_W'(4),  KW_CAT_W'(4)},
		'{"MAG:",        KW_LEN_W'(4),  KW_CAT_W'(4)},
		'{"MAGNET",      KW_LEN_W'(6),  KW_CAT_W'(4)},
		'{"FAILSAFE",    KW_LEN_W'(8),  KW_CAT_W'(5)},
		'{"RADIO",       KW_LEN_W'(5),  KW_CAT_W'(5)},
		'{"RC ",         KW_LEN_W'(3),  KW_CAT_W'(5)},
		'{"THROTTLE FS", KW_LEN_W'(11), KW_CAT_W'(5)},
		'{"GCS FS",      KW_LEN_W'(6),  KW_CAT_W'(5)},
		'{"VIB",         KW_LEN_W'(3),  KW_CAT_W'(6)},
		'{"GYRO",        KW_LEN_W'(4),  KW_CAT_W'(7)},
		'{"ACCEL",       KW_LEN_W'(5),  KW_CAT_W'(7)},
		'{"IMU",         KW_LEN_W'(3),  KW_CAT_W'(7)},
		'{"INS ",        KW_LEN_W'(4),  KW_CAT_W'(7)},
		'{"CALIBRAT",    KW_LEN_W'(8),  KW_CAT_W'(8)},
		'{"ARMING",      KW_LEN_W'(6),  KW_CAT_W'(9)},
		'{"DISARM",      KW_LEN_W'(6),  KW_CAT_W'(9)},
		'{"ARMED",       KW_LEN_W'(5),  KW_CAT_W'(9)}
	};

	// window byte 0 is the current character, byte k the k-th previous one
	function automatic logic [CAT_W-1:0] kw_hits(input logic [CHAR_W*WIN_LEN-1:0] win);
		logic [CAT_W-1:0] hits;
		logic             hit;
		hits = '0;
		for (int i = 0; i < KW_COUNT; i++) begin
			hit = (KW_TABLE[i].len != '0);
			for (int k = 0; k < WIN_LEN; k++) begin
				if (KW_LEN_W'(k) < KW_TABLE[i].len &&
				    KW_TABLE[i].text[CHAR_W*k +: CHAR_W] != win[CHAR_W*k +: CHAR_W]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				hits[KW_TABLE[i].cat] = 1'b1;
			end
		end
		return hits;
	endfunction

endpackage

FILE: design/message_keyword_classifier_unit.sv
// top level of the message keyword classifier
// depends on mkc_pkg for widths, keyword table and register indexes
//
// Usage:
//   input channel (in_valid / in_stall) carries one message character per
//   transfer with its severity and a last-character mark. output channel
//   (out_valid / out_stall) carries one result per message: category mask,
//   show decision and blink / invert style.
//   configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data), to be
//   written only while the block is idle; the block itself does not enforce this.
// Timing:
//   one character per cycle sustained, except while in_stall holds a last
//   character (see Stall). a character is captured in the input register and
//   matched against all keywords in parallel; when the last character leaves
//   the input register, the result is registered and out_valid rises.
// Reset:
//   history and category bits clear, registers go to their reset values,
//   both channels idle.
// Stall:
//   while a result waits under out_stall, ordinary characters keep flowing;
//   a following last character is held in the input register and in_stall
//   rises until the result is taken.
module message_keyword_classifier_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mkc_pkg::CHAR_W-1:0]           char_code,
	input  logic [mkc_pkg::SEV_W-1:0]            severity,
	input  logic                                 last_char,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mkc_pkg::CAT_W-1:0]            categories,
	output logic                                 show,
	output logic                                 blink,
	output logic                                 invert,
	input  logic                                 cfg_wr_en,
	input  logic [mkc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mkc_pkg::CFG_W-1:0]            cfg_data
);
	import mkc_pkg::*;

	logic [CAT_W-1:0]  allow_mask_q;
	logic [SEV_W-1:0]  level_limit_q;
	logic [SEV_W-1:0]  override_level_q;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic [SEV_W-1:0]  sev_s1;
	logic              last_s1;

	logic [CHAR_W-1:0] hist_q [HIST_LEN];
	logic [CAT_W-1:0]  cat_q;

	logic              out_valid_q;
	logic [CAT_W-1:0]  categories_q;
	logic              show_q;
	logic              blink_q;
	logic              invert_q;

	logic                       in_xfer;
	logic                       adv_s1;
	logic [CHAR_W*WIN_LEN-1:0]  win;
	logic [CAT_W-1:0]           cat_next;
	logic                       show_next;

	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_xfer  = in_valid && !in_stall;

	always_comb begin
		win[CHAR_W-1:0] = char_s1;
		for (int k = 0; k < HIST_LEN; k++) begin
			win[CHAR_W*(k+1) +: CHAR_W] = hist_q[k];
		end
	end

	assign cat_next = cat_q | kw_hits(win);

	always_comb begin
		if (sev_s1 <= override_level_q) begin
			show_next = 1'b1;
		end else if (sev_s1 > level_limit_q) begin
			show_next = 1'b0;
		end else if (allow_mask_q == '0) begin
			show_next = 1'b1;
		end else begin
			show_next = |(cat_next & allow_mask_q);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_mask_q     <= '0;
			level_limit_q    <= 3'd7;
			override_level_q <= 3'd2;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ALLOW_MASK:     allow_mask_q     <= cfg_data[CAT_W-1:0];
				CFG_LEVEL_LIMIT:    level_limit_q    <= cfg_data[SEV_W-1:0];
				CFG_OVERRIDE_LEVEL: override_level_q <= cfg_data[SEV_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1 <= char_code;
			sev_s1  <= severity;
			last_s1 <= last_char;
		end
	end

	// message history and categories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST_LEN; k++) begin
				hist_q[k] <= '0;
			end
			cat_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				for (int k = 0; k < HIST_LEN; k++) begin
					hist_q[k] <= '0;
				end
				cat_q <= '0;
			end else begin
				hist_q[0] <= char_s1;
				for (int k = 1; k < HIST_LEN; k++) begin
					hist_q[k] <= hist_q[k-1];
				end
				cat_q <= cat_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			categories_q <= cat_next;
			show_q       <= show_next;
			blink_q      <= (sev_s1 <= SEV_CRIT_MAX);
			invert_q     <= (sev_s1 inside {[SEV_CRIT_MAX + 3'd1 : SEV_WARN_MAX]});
		end
	end

	assign out_valid  = out_valid_q;
	assign categories = categories_q;
	assign show       = show_q;
	assign blink      = blink_q;
	assign invert     = invert_q;

endmodule

FILE: dv/message_keyword_classifier_unit_test.sv
// self-checking testbench for message_keyword_classifier_unit
// drives characters, register writes and stalls, and checks each message verdict
// against a keyword predictor or the directed table in this file; depends on mkc_pkg and the rtl
module message_keyword_classifier_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mkc_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 10;
	localparam int HIST           = HIST_LEN;
	localparam int PHASES         = 10;
	localparam int PHASE_CHARS    = 125;
	localparam int SETTLE_CYCLES  = 4;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

	typedef struct packed {
		logic [CAT_W-1:0] cats;
		logic             show;
		logic             blink;
		logic             invert;
	} verdict_t;

	typedef struct packed {
		logic [8*WIN_LEN-1:0] text;
		logic [3:0]           len;
		logic [SEV_W-1:0]     sev;
		bit                   typed;
		verdict_t             want;
	} directed_row_t;

	localparam directed_row_t DIRECTED [8] = '{
		'{8'hFF,               4'd1,  3'd7, 1'b1, '{10'h000, 1'b1, 1'b0, 1'b0}},
		'{"GPS",               4'd3,  3'd0, 1'b1, '{10'h004, 1'b1, 1'b1, 1'b0}},
		'{"THROTTLE FS",       4'd11, 3'd3, 1'b1, '{10'h020, 1'b1, 1'b0, 1'b1}},
		'{{"DC", 8'h00, "M"},  4'd4,  3'd4, 1'b1, '{10'h000, 1'b1, 1'b0, 1'b1}},
		'{"vib",               4'd3,  3'd5, 1'b1, '{10'h000, 1'b1, 1'b0, 1'b0}},
		'{"GP",                4'd2,  3'd6, 1'b1, '{10'h000, 1'b1, 1'b0, 1'b0}},
		'{"S",                 4'd1,  3'd1, 1'b1, '{10'h000, 1'b1, 1'b1, 1'b0}},
		'{"PA:ARMED",          4'd8,  3'd2, 1'b0, '{10'h000, 1'b0, 1'b0, 1'b0}}
	};

	string keyword_text [30] = '{
		"PREARM", "PA:", "EKF", "AHRS", "DCM", "GPS", "GNSS", "BATT", "VOLT", "POWER",
		"CURRENT", "CAPACITY", "COMPASS", "MAG ", "MAG:", "MAGNET", "FAILSAFE", "RADIO",
		"RC ", "THROTTLE FS", "GCS FS", "VIB", "GYRO", "ACCEL", "IMU", "INS ",
		"CALIBRAT", "ARMING", "DISARM", "ARMED"
	};
	int keyword_cat [30] = '{
		0, 0, 1, 1, 1, 2, 2, 3, 3, 3,
		3, 3, 4, 4, 4, 4, 5, 5,
		5, 5, 5, 6, 7, 7, 7, 7,
		8, 9, 9, 9
	};

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [CHAR_W-1:0]    char_code  = '0;
	logic [SEV_W-1:0]     severity   = '0;
	logic                 last_char  = 1'b0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic [CAT_W-1:0]     categories;
	logic                 show;
	logic                 blink;
	logic                 invert;
	logic                 cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_W-1:0]     cfg_data   = '0;

	logic [CHAR_W-1:0] char_hist [HIST] = '{default: '0};
	logic [CAT_W-1:0]  cat_acc          = '0;
	logic [CAT_W-1:0]  allow_mask_cfg   = '0;
	logic [SEV_W-1:0]  level_limit_cfg  = 3'd7;
	logic [SEV_W-1:0]  override_cfg     = 3'd2;

	verdict_t pending_verdicts [$];
	int       fault_count = 0;
	int       chars_sent  = 0;
	int       quiet_cycles = 0;
	bit       sender_idle_on = 1'b0;
	bit       sink_stall_on  = 1'b0;
	bit       hold_req       = 1'b0;

	message_keyword_classifier_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.severity   (severity),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.categories (categories),
		.show       (show),
		.blink      (blink),
		.invert     (invert),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bit classify_char(input logic [CHAR_W-1:0] c, input logic [SEV_W-1:0] sev,
	                                     input logic last, output verdict_t v);
		bit hit;
		int n;
		v = '0;
		for (int i = 0; i < $size(keyword_text); i++) begin
			n = keyword_text[i].len();
			hit = (keyword_text[i][n-1] == c);
			for (int k = 1; k < n; k++) begin
				if (char_hist[k-1] != keyword_text[i][n-1-k])
					hit = 1'b0;
			end
			if (hit)
				cat_acc[keyword_cat[i]] = 1'b1;
		end
		if (!last) begin
			for (int k = HIST - 1; k > 0; k--)
				char_hist[k] = char_hist[k-1];
			char_hist[0] = c;
			return 1'b0;
		end
		v.cats = cat_acc;
		if (sev <= override_cfg)
			v.show = 1'b1;
		else if (sev > level_limit_cfg)
			v.show = 1'b0;
		else if (allow_mask_cfg == '0)
			v.show = 1'b1;
		else
			v.show = |(cat_acc & allow_mask_cfg);
		v.blink  = (sev <= SEV_CRIT_MAX);
		v.invert = (sev > SEV_CRIT_MAX) && (sev <= SEV_WARN_MAX);
		char_hist = '{default: '0};
		cat_acc = '0;
		return 1'b1;
	endfunction

	function automatic int pause_len(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [CHAR_W-1:0] filler_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 8'h41 + 8'($urandom_range(0, 25));
		if (r == 7)
			return " ";
		if (r == 8)
			return ":";
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	// entered and left at a falling edge
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic [SEV_W-1:0] sev,
	                         input logic last, input bit typed, input verdict_t want);
		verdict_t v;
		int gap;
		gap = pause_len(sender_idle_on);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		severity  <= sev;
		last_char <= last;
		do @(posedge clk); while (in_stall);
		if (classify_char(c, sev, last, v))
			pending_verdicts.push_back(typed ? want : v);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_message();
		logic [CHAR_W-1:0] text [$];
		logic [SEV_W-1:0]  sev;
		string             word;
		text = {};
		sev = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(8, 14)) text.push_back(filler_char());
			else
				repeat ($urandom_range(0, 4)) text.push_back(filler_char());
			repeat ($urandom_range(1, 2)) begin
				word = keyword_text[$urandom_range(0, $size(keyword_text) - 1)];
				for (int i = 0; i < word.len(); i++)
					text.push_back(word[i]);
				// broken keyword
				if ($urandom_range(0, 7) == 0)
					text[$urandom_range(0, text.size() - 1)] = filler_char();
				repeat ($urandom_range(0, 3)) text.push_back(filler_char());
			end
		end
		for (int i = 0; i < text.size(); i++) begin
			if (i == text.size() - 1)
				send_char(text[i], sev, 1'b1, 1'b0, '0);
			else
				send_char(text[i], 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
		end
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_ALLOW_MASK:     allow_mask_cfg  = data[CAT_W-1:0];
			CFG_LEVEL_LIMIT:    level_limit_cfg = data[SEV_W-1:0];
			CFG_OVERRIDE_LEVEL: override_cfg    = data[SEV_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_phase_config(input int p);
		case (p)
			0: begin
				cfg_write(CFG_ALLOW_MASK, 10'h3FF);
				cfg_write(CFG_LEVEL_LIMIT, 10'h3F8);
				cfg_write(CFG_OVERRIDE_LEVEL, 10'h000);
			end
			1: begin
				cfg_write(CFG_ALLOW_MASK, 10'h000);
				cfg_write(CFG_LEVEL_LIMIT, 10'h007);
				cfg_write(CFG_OVERRIDE_LEVEL, 10'h3FF);
			end
			2: begin
				cfg_write(CFG_ALLOW_MASK, 10'h001);
				cfg_write(CFG_LEVEL_LIMIT, 10'h005);
				cfg_write(CFG_OVERRIDE_LEVEL, 10'h001);
			end
			3: begin
				cfg_write(CFG_SPARE_INDEX, 10'($urandom_range(0, 1023)));
				cfg_write(CFG_ALLOW_MASK, 10'h200);
			end
			default: begin
				cfg_write(CFG_ALLOW_MASK, 10'($urandom_range(0, 1023)));
				cfg_write(CFG_LEVEL_LIMIT, 10'($urandom_range(0, 1023)));
				cfg_write(CFG_OVERRIDE_LEVEL, 10'($urandom_range(0, 1023)));
				if ($urandom_range(0, 2) == 0)
					cfg_write(CFG_SPARE_INDEX, 10'($urandom_range(0, 1023)));
			end
		endcase
	endtask

	initial begin : stimulus
		int phase_start;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sender_idle_on = 1'b1;
		sink_stall_on  = 1'b1;
		foreach (DIRECTED[r]) begin
			for (int i = DIRECTED[r].len - 1; i >= 0; i--) begin
				if (i == 0)
					send_char(DIRECTED[r].text[8*i +: 8], DIRECTED[r].sev, 1'b1,
					          DIRECTED[r].typed, DIRECTED[r].want);
				else
					send_char(DIRECTED[r].text[8*i +: 8], 3'($urandom_range(0, 7)), 1'b0,
					          1'b0, '0);
			end
		end
		drain_results();

		for (int p = 0; p < PHASES; p++) begin
			set_phase_config(p);
			sender_idle_on = ($urandom_range(0, 3) != 0);
			sink_stall_on  = ($urandom_range(0, 3) != 0);
			// long receiver hold-off with the sender running flat out
			if (p == 2 || p == 6) begin
				sender_idle_on = 1'b0;
				hold_req = 1'b1;
			end
			phase_start = chars_sent;
			while (chars_sent - phase_start < PHASE_CHARS)
				send_random_message();
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && pending_verdicts.size() == 0)
			$display("[message_keyword_classifier_unit] OK");
		else
			$display("[message_keyword_classifier_unit] ERROR");
		$finish;
	end

	initial begin : result_sink
		int n;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				n = pause_len(sink_stall_on);
				if (n == 0) begin
					out_stall <= 1'b0;
					@(negedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		verdict_t got;
		verdict_t want;
		bit       bad;
		if (arst_n && out_valid && !out_stall) begin
			got = {categories, show, blink, invert};
			if (pending_verdicts.size() == 0) begin
				note_fault($sformatf("unexpected result: cats=%h show=%b blink=%b invert=%b",
				                     got.cats, got.show, got.blink, got.invert));
			end else begin
				want = pending_verdicts.pop_front();
				bad = (got.cats !== want.cats) || (got.show !== want.show) ||
				      (got.blink !== want.blink) || (got.invert !== want.invert);
				if (bad)
					note_fault($sformatf({"mismatch: expected cats=%h show=%b blink=%b ",
					                      "invert=%b, got cats=%h show=%b blink=%b invert=%b"},
					                     want.cats, want.show, want.blink, want.invert,
					                     got.cats, got.show, got.blink, got.invert));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", quiet_cycles);
			$display("[message_keyword_classifier_unit] ERROR");
			$finish;
		end
	end

endmodule

FILE: message_keyword_classifier_unit.f
design/mkc_pkg.sv
design/message_keyword_classifier_unit.sv
dv/message_keyword_classifier_unit_test.sv
